[sv/trc_pkg.sv]
// ============================================================================
// Thermistor reading to Celsius: shared types and constants
// Widths, fixed-point constants and clamp codes used by the datapath files.
// ============================================================================
package trc_pkg;

  localparam int OUT_FRAC_BITS_DEF = 8;

  localparam int IN_W   = 16;
  localparam int TEMP_W = 16;
  localparam int CODE_W = 2;

  // Numerator and denominator of the resistance ratio fit in 15 bits.
  localparam int N_W        = 15;
  localparam int LOG_K_W    = 4;
  localparam int LOG_FRAC_W = 32;
  localparam int LOG_W      = LOG_K_W + LOG_FRAC_W;
  // One normalize stage plus one squaring stage per fraction bit.
  localparam int LOG_STAGES = LOG_FRAC_W + 1;

  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [17:0] RECIP_125  = 18'd134218;   // ceil(2^24 / 125)
  localparam logic [18:0] C1_COEF    = 19'd291000;
  localparam logic [8:0]  C3_COEF    = 9'd428;
  localparam logic [55:0] P_BASE     = 56'd2679000 << 32;
  localparam int          P16_W      = 40;
  // 1e9 scaled so that the first quotient bit is the top one that can be set.
  localparam logic [P16_W-1:0] DIV_INIT = 40'd1000000000 << 7;

  typedef enum logic [CODE_W-1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_e;

endpackage

[sv/trc_if.sv]
// ============================================================================
// Thermistor reading to Celsius: stream interfaces
// Valid/ready channels for readings in and temperatures out.
// ============================================================================
interface trc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [trc_pkg::IN_W-1:0]     raw_reading;

  modport source (output valid, output raw_reading, input ready);
  modport sink (input valid, input raw_reading, output ready);
endinterface

interface trc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [trc_pkg::TEMP_W-1:0]   temperature_q8;
  logic [trc_pkg::CODE_W-1:0]          clamp_code;

  modport source (output valid, output temperature_q8, output clamp_code, input ready);
  modport sink (input valid, input temperature_q8, input clamp_code, output ready);
endinterface

[sv/trc_log2.sv]
// ============================================================================
// Pipelined base-2 logarithm
// Normalizes the operand, then extracts one fraction bit per stage by
// squaring the mantissa. Result is the integer part over a 32-bit fraction.
// ============================================================================
module trc_log2 (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [trc_pkg::N_W-1:0]      n_i,
  output logic [trc_pkg::LOG_W-1:0]    lg_o
);

  localparam int SQ = trc_pkg::LOG_FRAC_W;

  logic [31:0]                    m_q [0:SQ];
  logic [trc_pkg::LOG_K_W-1:0]    k_q [0:SQ];
  logic [SQ-1:0]                  f_q [0:SQ];

  logic [trc_pkg::N_W-1:0]        nn;
  logic [trc_pkg::LOG_K_W-1:0]    k_d;
  logic [31:0]                    m_d;

  always_comb begin
    nn = (n_i == '0) ? trc_pkg::N_W'(1) : n_i;
    k_d = '0;
    for (int i = 0; i < trc_pkg::N_W; i++) begin
      if (nn[i]) k_d = trc_pkg::LOG_K_W'(i);
    end
    m_d = 32'(nn) << (5'd31 - 5'(k_d));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m_d;
      k_q[0] <= k_d;
      f_q[0] <= '0;
    end
  end

  for (genvar i = 1; i <= SQ; i++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;

    assign sq = m_q[i-1] * m_q[i-1];
    assign t  = sq[63:31];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i] <= t[32] ? t[32:1] : t[31:0];
        f_q[i] <= {f_q[i-1][SQ-2:0], t[32]};
        k_q[i] <= k_q[i-1];
      end
    end
  end

  assign lg_o = {k_q[SQ], f_q[SQ]};

endmodule

[sv/thermistor_reading_to_celsius_top.sv]
// ============================================================================
// Thermistor reading to Celsius
// Reading -> millivolts -> resistance -> Steinhart-Hart temperature.
// ============================================================================
// Data passes through stages A and B, two 33-stage log pipelines, stages C
// to G, one restoring-division stage per quotient bit and the output register.
// Throughput: one transaction per cycle; the whole pipeline holds only when
// its last stage carries a result and the output register is not drained.
// Reset clears all valid bits; data registers are not reset.
module thermistor_reading_to_celsius_top #(
  parameter int OUT_FRAC_BITS = trc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  trc_in_if.sink        reading_i,
  trc_out_if.source     result_o
);

  localparam int QB = OUT_FRAC_BITS + 13;
  localparam longint unsigned OFFSET =
    ((64'd27315 << (OUT_FRAC_BITS + 4)) + 64'd50) / 64'd100;
  localparam int LS = trc_pkg::LOG_STAGES;
  localparam int PW = trc_pkg::P16_W;

  logic en;
  logic last_v;
  logic out_valid_q;

  assign en = !(last_v && out_valid_q && !result_o.ready);
  assign reading_i.ready = en;

  // ---------------------------------------------------------------- stage A
  logic [15:0] mag;
  logic [17:0] y3;
  logic [35:0] corr_p;
  logic        va_q, sign_a_q;
  logic [15:0] mag_a_q;
  logic [11:0] corr_a_q;

  assign mag    = reading_i.raw_reading[15] ? (~reading_i.raw_reading + 16'd1)
                                            : reading_i.raw_reading;
  assign y3     = 18'(mag) + 18'({mag, 1'b0});
  assign corr_p = y3 * trc_pkg::RECIP_125;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= reading_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sign_a_q <= reading_i.raw_reading[15];
      mag_a_q  <= mag;
      corr_a_q <= corr_p[35:24];
    end
  end

  // ---------------------------------------------------------------- stage B
  logic [16:0]                 q17;
  logic signed [17:0]          vq, vs, dd;
  logic signed [19:0]          d20, numw;
  logic [trc_pkg::N_W-1:0]     num_d, den_d;
  trc_pkg::clamp_e             code_d;
  logic                        vb_q;
  logic [trc_pkg::N_W-1:0]     num_b_q, den_b_q;
  trc_pkg::clamp_e             code_b_q;

  always_comb begin
    q17 = 17'(mag_a_q) + 17'(corr_a_q);
    vq  = sign_a_q ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
    priority if (vq > 18'sd32767) begin
      vs = 18'sd32767;
    end else if (vq < -18'sd32768) begin
      vs = -18'sd32768;
    end else begin
      vs = vq;
    end
    dd   = vs + 18'sd1625;
    d20  = 20'(dd);
    numw = 20'sd33000 - ((d20 <<< 3) + (d20 <<< 1));
    priority if (dd == 18'sd0 || (dd > 18'sd0 && dd < 18'sd81)) begin
      code_d = trc_pkg::CLAMP_HIGH;
      num_d  = trc_pkg::N_W'(400);
      den_d  = trc_pkg::N_W'(1);
    end else if (dd < 18'sd0 || dd > 18'sd3000) begin
      code_d = trc_pkg::CLAMP_LOW;
      num_d  = trc_pkg::N_W'(1);
      den_d  = trc_pkg::N_W'(1);
    end else begin
      code_d = trc_pkg::CLAMP_NONE;
      num_d  = numw[trc_pkg::N_W-1:0];
      den_d  = dd[trc_pkg::N_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_b_q  <= num_d;
      den_b_q  <= den_d;
      code_b_q <= code_d;
    end
  end

  // ------------------------------------------------------------ log lanes
  logic [trc_pkg::LOG_W-1:0] lg_num, lg_den;
  logic                      vl_q [0:LS-1];
  trc_pkg::clamp_e           cl_q [0:LS-1];

  trc_log2 u_log_num (.clk_i(clk_i), .en_i(en), .n_i(num_b_q), .lg_o(lg_num));
  trc_log2 u_log_den (.clk_i(clk_i), .en_i(en), .n_i(den_b_q), .lg_o(lg_den));

  for (genvar i = 0; i < LS; i++) begin : g_lane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[i] <= 1'b0;
      end else if (en) begin
        vl_q[i] <= (i == 0) ? vb_q : vl_q[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        cl_q[i] <= (i == 0) ? code_b_q : cl_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage C
  logic [trc_pkg::LOG_W-1:0] lg;
  logic [51:0]               ph;
  logic [47:0]               pl;
  logic                      vc_q;
  trc_pkg::clamp_e           cc_q;
  logic [51:0]               ph_c_q;
  logic [31:0]               pl_c_q;

  // The ratio is at least one, so the difference never goes negative.
  assign lg = lg_num - lg_den;
  assign ph = lg[trc_pkg::LOG_W-1:16] * trc_pkg::LN2_Q32;
  assign pl = lg[15:0] * trc_pkg::LN2_Q32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vl_q[LS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q   <= cl_q[LS-1];
      ph_c_q <= ph;
      pl_c_q <= pl[47:16];
    end
  end

  // ---------------------------------------------------------------- stage D
  logic [52:0]     lsum;
  logic            vd_q;
  trc_pkg::clamp_e cd_q;
  logic [35:0]     lq_d_q;

  assign lsum = 53'(ph_c_q) + 53'(pl_c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q   <= cc_q;
      lq_d_q <= lsum[51:16];
    end
  end

  // ---------------------------------------------------------------- stage E
  logic [27:0]     l24;
  logic [55:0]     sq24;
  logic [54:0]     p1;
  logic            ve_q;
  trc_pkg::clamp_e ce_q;
  logic [31:0]     l2_e_q;
  logic [27:0]     l24_e_q;
  logic [54:0]     p1_e_q;

  assign l24  = lq_d_q[35:8];
  assign sq24 = l24 * l24;
  assign p1   = trc_pkg::C1_COEF * lq_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ce_q    <= cd_q;
      l2_e_q  <= sq24[55:24];
      l24_e_q <= l24;
      p1_e_q  <= p1;
    end
  end

  // ---------------------------------------------------------------- stage F
  logic [59:0]     cube;
  logic            vf_q;
  trc_pkg::clamp_e cf_q;
  logic [31:0]     l3_f_q;
  logic [54:0]     p1_f_q;

  assign cube = l2_e_q * l24_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cf_q   <= ce_q;
      l3_f_q <= cube[55:24];
      p1_f_q <= p1_e_q;
    end
  end

  // ---------------------------------------------------------------- stage G
  logic [40:0]     p3;
  logic [55:0]     psum;
  logic            vg_q;
  trc_pkg::clamp_e cg_q;
  logic [PW-1:0]   p16_g_q;

  assign p3   = trc_pkg::C3_COEF * l3_f_q;
  assign psum = trc_pkg::P_BASE + 56'(p1_f_q) + 56'({p3, 8'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en) begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cg_q    <= cf_q;
      p16_g_q <= psum[55:16];
    end
  end

  // ------------------------------------------------- restoring divider
  logic            dv_q [0:QB-1];
  trc_pkg::clamp_e dc_q [0:QB-1];
  logic [PW-1:0]   dr_q [0:QB-1];
  logic [PW-1:0]   dp_q [0:QB-1];
  logic [QB-1:0]   dq_q [0:QB-1];

  assign last_v = dv_q[QB-1];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic            v_prev;
    trc_pkg::clamp_e c_prev;
    logic [PW-1:0]   r_prev, p_prev;
    logic [QB-1:0]   q_prev;
    logic [PW:0]     r2, pe;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_prev = vg_q;
      assign c_prev = cg_q;
      assign r_prev = trc_pkg::DIV_INIT;
      assign p_prev = p16_g_q;
      assign q_prev = '0;
    end else begin : g_next
      assign v_prev = dv_q[j-1];
      assign c_prev = dc_q[j-1];
      assign r_prev = dr_q[j-1];
      assign p_prev = dp_q[j-1];
      assign q_prev = dq_q[j-1];
    end

    assign r2 = {r_prev, 1'b0};
    assign pe = {1'b0, p_prev};
    assign ge = (r2 >= pe);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[j] <= c_prev;
        dp_q[j] <= p_prev;
        dr_q[j] <= ge ? PW'(r2 - pe) : PW'(r2);
        dq_q[j] <= {q_prev[QB-2:0], ge};
      end
    end
  end

  // -------------------------------------------------- output register
  logic signed [31:0] x32, t32;
  logic signed [15:0] t_sat;
  logic               out_ld;
  logic signed [15:0] temp_q;
  trc_pkg::clamp_e    code_q;

  always_comb begin
    x32 = $signed(32'(dq_q[QB-1])) - $signed(32'(OFFSET));
    t32 = (x32 + 32'sd8) >>> 4;
    priority if (t32 > 32'sd32767) begin
      t_sat = 16'sh7fff;
    end else if (t32 < -32'sd32768) begin
      t_sat = 16'sh8000;
    end else begin
      t_sat = t32[15:0];
    end
  end

  assign out_ld = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= last_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      temp_q <= t_sat;
      code_q <= dc_q[QB-1];
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.temperature_q8 = temp_q;
  assign result_o.clamp_code     = code_q;

endmodule
